// ----- sv/tolerance_band_pair_matcher_defines.svh -----
// assertion macros for the tolerance band pair matcher
`ifndef TOLERANCE_BAND_PAIR_MATCHER_DEFINES_SVH
`define TOLERANCE_BAND_PAIR_MATCHER_DEFINES_SVH
`ifndef SYNTH
`define TBPM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
`define TBPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define TBPM_ASSERT_SAME(label, clk, rst, ante, cons)
`define TBPM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- sv/tbpm_pkg.sv -----
// shared constants, types and the fit check of the pair matcher
package tbpm_pkg;
   localparam int WINDOW = 10;
   localparam int SLOT_W = $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int SIZE_W = 18;
   localparam int TAG_W = 16;
   localparam int CSR_IDX_W = 8;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 88;

   localparam logic [CSR_IDX_W-1:0] CSR_CLEARANCE_MIN = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEARANCE_MAX = 8'd1;
   localparam logic [SIZE_W-1:0] CLEARANCE_MIN_RESET = 18'd500;
   localparam logic [SIZE_W-1:0] CLEARANCE_MAX_RESET = 18'd750;
   localparam logic STATUS_MATCH = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   // commands from the controller, at most one per cycle
   typedef struct packed {
      logic store;
      logic fit_row;
      logic search_init;
      logic search_step;
      logic emit_step;
      logic fail;
      logic commit;
   } cmd_type;

   // status back from the datapath
   typedef struct packed {
      logic last_slot;
      logic full;
      logic fit_done;
      logic search_done;
      logic found;
      logic emit_done;
      logic rsp_free;
   } status_type;

   // hole fits shaft when hole - shaft lies inside the band
   function automatic logic fits(input logic [SIZE_W-1:0] hole,
                                 input logic [SIZE_W-1:0] shaft,
                                 input logic [SIZE_W-1:0] cmin,
                                 input logic [SIZE_W-1:0] cmax);
      logic [SIZE_W:0] diff;
      diff = {1'b0, hole} - {1'b0, shaft};
      return !diff[SIZE_W] && (diff[SIZE_W-1:0] >= cmin) && (diff[SIZE_W-1:0] <= cmax);
   endfunction
endpackage

// ----- sv/tbpm_ctrl.sv -----
// controller state machine of the pair matcher
module tbpm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  tbpm_pkg::status_type status,
   output tbpm_pkg::cmd_type    cmd
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_FIT, ST_SEARCH, ST_EMIT, ST_FAIL, ST_HALT
   } state_type;

   state_type state_ff;

   // input is taken while waiting for items and, ignored, once halted
   assign req_tready = (state_ff == ST_IDLE) || (state_ff == ST_HALT);

   // command decode
   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: cmd.store = req_tvalid;
         ST_FIT: begin
            cmd.fit_row = !status.fit_done;
            cmd.search_init = status.fit_done;
         end
         ST_SEARCH: cmd.search_step = !status.search_done;
         ST_EMIT: begin
            cmd.commit = status.emit_done;
            cmd.emit_step = !status.emit_done && status.rsp_free;
         end
         ST_FAIL: cmd.fail = status.rsp_free;
         ST_HALT: cmd = '0;
         default: cmd = '0;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: if (req_tvalid && status.last_slot) state_ff <= ST_FIT;
            ST_FIT: if (status.fit_done) state_ff <= ST_SEARCH;
            ST_SEARCH: begin
               if (status.search_done) state_ff <= status.found ? ST_EMIT : ST_FAIL;
            end
            ST_EMIT: if (status.emit_done) state_ff <= ST_IDLE;
            ST_FAIL: if (status.rsp_free) state_ff <= ST_HALT;
            ST_HALT: state_ff <= ST_HALT;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// ----- sv/tbpm_datapath.sv -----
// window storage, fit table, assignment search and result register
module tbpm_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [tbpm_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                csr_valid,
   input  logic [tbpm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tbpm_pkg::SIZE_W-1:0]         csr_data,
   input  tbpm_pkg::cmd_type                   cmd,
   output tbpm_pkg::status_type                status,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tbpm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);
   localparam int W = tbpm_pkg::WINDOW;
   localparam int SW = tbpm_pkg::SLOT_W;
   localparam int CW = tbpm_pkg::CNT_W;
   localparam int ZW = tbpm_pkg::SIZE_W;
   localparam int TW = tbpm_pkg::TAG_W;

   // configuration
   logic [ZW-1:0] clr_min_ff, clr_max_ff;
   // window contents and compaction buffer
   logic [ZW-1:0] shaft_win_ff [W];
   logic [ZW-1:0] hole_win_ff [W];
   logic [TW-1:0] shaft_tag_ff [W];
   logic [TW-1:0] hole_tag_ff [W];
   logic [ZW-1:0] nxt_shaft_ff [W];
   logic [ZW-1:0] nxt_hole_ff [W];
   logic [TW-1:0] nxt_shaft_tag_ff [W];
   logic [TW-1:0] nxt_hole_tag_ff [W];
   logic [CW-1:0] fill_ff;
   logic [TW-1:0] arrival_ff, arrival_in;
   // fit table, one row per hole
   logic [W-1:0]  fit_ff [W];
   logic [CW-1:0] row_ff;
   logic          any_fit;
   // depth-first search state
   logic [CW-1:0] lvl_ff, lvl_in, next_ff, next_in;
   logic [SW-1:0] perm_ff [W];
   logic [CW-1:0] cnt_ff [W+1];
   logic [W-1:0]  used_ff, used_in;
   logic [CW-1:0] best_cnt_ff, best_cnt_in;
   logic [SW-1:0] best_perm_ff [W];
   logic          done_ff, done_in, take_best, descend;
   // emit state
   logic [CW-1:0] hole_i_ff, kept_ff, emitted_ff;
   logic          rsp_valid_ff, rsp_user_ff, rsp_last_ff;
   logic [tbpm_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic [SW-1:0] fill_slot, row_slot, lvl_slot, prev_slot, next_slot, hole_slot, kept_slot;
   logic [SW-1:0] emit_shaft;
   logic [CW-1:0] lvl_prev, cur_cnt;
   logic [CW:0]   bound;
   logic          pair_fit;
   logic [ZW-1:0] in_shaft, in_hole;

   assign in_shaft = req_tdata[ZW-1:0];
   assign in_hole = req_tdata[2*ZW-1:ZW];
   assign fill_slot = fill_ff[SW-1:0];
   assign row_slot = row_ff[SW-1:0];
   assign lvl_slot = lvl_ff[SW-1:0];
   assign lvl_prev = lvl_ff - CW'(1);
   assign prev_slot = lvl_prev[SW-1:0];
   assign next_slot = next_ff[SW-1:0];
   assign hole_slot = hole_i_ff[SW-1:0];
   assign kept_slot = kept_ff[SW-1:0];
   assign cur_cnt = cnt_ff[lvl_ff];
   assign bound = {1'b0, cur_cnt} + (CW+1)'(W) - {1'b0, lvl_ff};
   assign emit_shaft = best_perm_ff[hole_slot];
   assign pair_fit = fit_ff[hole_slot][emit_shaft];
   assign arrival_in = arrival_ff + TW'(1);

   // any fit at all in the table
   always_comb begin
      any_fit = 1'b0;
      for (int i = 0; i < W; i++) any_fit = any_fit | (|fit_ff[i]);
   end

   // status towards the controller
   always_comb begin
      status.last_slot = (fill_ff == CW'(W - 1));
      status.full = (fill_ff == CW'(W));
      status.fit_done = (row_ff == CW'(W));
      status.search_done = done_ff;
      status.found = (best_cnt_ff != '0);
      status.emit_done = (hole_i_ff == CW'(W));
      status.rsp_free = !rsp_valid_ff || rsp_tready;
   end

   // one search step: leaf, prune, skip used shaft, descend or backtrack
   always_comb begin
      lvl_in = lvl_ff;
      next_in = next_ff;
      used_in = used_ff;
      best_cnt_in = best_cnt_ff;
      done_in = done_ff;
      take_best = 1'b0;
      descend = 1'b0;
      if (lvl_ff == CW'(W) && cur_cnt == CW'(W) && cur_cnt > best_cnt_ff) begin
         take_best = 1'b1;
         best_cnt_in = cur_cnt;
         done_in = 1'b1;
      end else if (lvl_ff != CW'(W) && bound > {1'b0, best_cnt_ff}
                   && next_ff != CW'(W)) begin
         if (used_ff[next_slot]) begin
            next_in = next_ff + CW'(1);
         end else begin
            descend = 1'b1;
            used_in[next_slot] = 1'b1;
            lvl_in = lvl_ff + CW'(1);
            next_in = '0;
         end
      end else begin
         if (lvl_ff == CW'(W) && cur_cnt > best_cnt_ff) begin
            take_best = 1'b1;
            best_cnt_in = cur_cnt;
         end
         if (lvl_ff == '0) begin
            done_in = 1'b1;
         end else begin
            lvl_in = lvl_prev;
            used_in[perm_ff[prev_slot]] = 1'b0;
            next_in = {{(CW-SW){1'b0}}, perm_ff[prev_slot]} + CW'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_min_ff <= tbpm_pkg::CLEARANCE_MIN_RESET;
         clr_max_ff <= tbpm_pkg::CLEARANCE_MAX_RESET;
         fill_ff <= '0;
         arrival_ff <= '0;
         row_ff <= '0;
         lvl_ff <= '0;
         next_ff <= '0;
         used_ff <= '0;
         best_cnt_ff <= '0;
         done_ff <= 1'b0;
         hole_i_ff <= '0;
         kept_ff <= '0;
         emitted_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_index == tbpm_pkg::CSR_CLEARANCE_MIN) clr_min_ff <= csr_data;
         if (csr_valid && csr_index == tbpm_pkg::CSR_CLEARANCE_MAX) clr_max_ff <= csr_data;
         // result register loads a new transfer or empties on acceptance
         if (cmd.fail || (cmd.emit_step && pair_fit)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.store) begin
            fill_ff <= fill_ff + CW'(1);
            arrival_ff <= arrival_in;
            row_ff <= '0;
         end
         if (cmd.fit_row) row_ff <= row_ff + CW'(1);
         // an empty fit table ends the search at once
         if (cmd.search_init) begin
            lvl_ff <= '0;
            next_ff <= '0;
            used_ff <= '0;
            best_cnt_ff <= '0;
            done_ff <= !any_fit;
            hole_i_ff <= '0;
            kept_ff <= '0;
            emitted_ff <= '0;
         end
         if (cmd.search_step) begin
            lvl_ff <= lvl_in;
            next_ff <= next_in;
            used_ff <= used_in;
            best_cnt_ff <= best_cnt_in;
            done_ff <= done_in;
         end
         if (cmd.emit_step) begin
            hole_i_ff <= hole_i_ff + CW'(1);
            if (pair_fit) begin
               emitted_ff <= emitted_ff + CW'(1);
            end else begin
               kept_ff <= kept_ff + CW'(1);
            end
         end
         if (cmd.commit) fill_ff <= kept_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         shaft_win_ff[fill_slot] <= in_shaft;
         hole_win_ff[fill_slot] <= in_hole;
         shaft_tag_ff[fill_slot] <= arrival_in;
         hole_tag_ff[fill_slot] <= arrival_in;
      end
      if (cmd.fit_row) begin
         for (int j = 0; j < W; j++) begin
            fit_ff[row_slot][j] <= tbpm_pkg::fits(hole_win_ff[row_slot], shaft_win_ff[j],
                                                  clr_min_ff, clr_max_ff);
         end
      end
      if (cmd.search_init) cnt_ff[0] <= '0;
      if (cmd.search_step && descend) begin
         perm_ff[lvl_slot] <= next_slot;
         cnt_ff[lvl_ff + CW'(1)] <= cur_cnt + CW'(fit_ff[lvl_slot][next_slot]);
      end
      if (cmd.search_step && take_best) begin
         for (int k = 0; k < W; k++) best_perm_ff[k] <= perm_ff[k];
      end
      if (cmd.emit_step) begin
         if (pair_fit) begin
            rsp_user_ff <= tbpm_pkg::STATUS_MATCH;
            rsp_last_ff <= (emitted_ff + CW'(1) == best_cnt_ff);
            rsp_data_ff <= {2'b00,
                            hole_win_ff[hole_slot] - shaft_win_ff[emit_shaft],
                            hole_win_ff[hole_slot], hole_tag_ff[hole_slot],
                            shaft_win_ff[emit_shaft], shaft_tag_ff[emit_shaft]};
         end else begin
            nxt_shaft_ff[kept_slot] <= shaft_win_ff[emit_shaft];
            nxt_shaft_tag_ff[kept_slot] <= shaft_tag_ff[emit_shaft];
            nxt_hole_ff[kept_slot] <= hole_win_ff[hole_slot];
            nxt_hole_tag_ff[kept_slot] <= hole_tag_ff[hole_slot];
         end
      end
      if (cmd.fail) begin
         rsp_user_ff <= tbpm_pkg::STATUS_FAIL;
         rsp_last_ff <= 1'b1;
         rsp_data_ff <= '0;
      end
      // entries beyond the kept count are rewritten before use
      if (cmd.commit) begin
         for (int k = 0; k < W; k++) begin
            shaft_win_ff[k] <= nxt_shaft_ff[k];
            shaft_tag_ff[k] <= nxt_shaft_tag_ff[k];
            hole_win_ff[k] <= nxt_hole_ff[k];
            hole_tag_ff[k] <= nxt_hole_tag_ff[k];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;
   assign rsp_tlast = rsp_last_ff;
endmodule

// ----- sv/tolerance_band_pair_matcher.sv -----
// top level of the tolerance band pair matcher
// Usage: each req transfer carries one shaft and one hole diameter. Ten pairs fill
// the window; the tenth starts a batch. A hole fits a shaft when hole minus shaft
// lies within [clearance_min, clearance_max], set through the csr write channel
// (index 0 and 1; the user must write them only while idle, the block does not
// enforce it; csr_ready is always high). A batch builds the fit table row by row
// and then starts the search; a depth-first search over shaft to hole assignments
// in lexicographic order proceeds in search steps: 56 steps when the first
// assignment is a full match, more when some pairs fit but no full match exists;
// an empty fit table ends the search at once.
// Hole slots are then visited in order, waiting while rsp is stalled: fitting
// pairs leave on rsp in hole order, at most one per cycle, tlast on the final one;
// unfit pairs are compacted into the window. New items are refused during a batch.
// If nothing fits, one rsp transfer with tuser high and tlast high goes out and the
// block halts: req is then accepted and ignored until reset.
// A stalled rsp holds the result register and pauses the result sequence.
// Reset (synchronous) empties the window, clears the arrival count and restores
// the clearance band to 500 and 750.
`include "tolerance_band_pair_matcher_defines.svh"
module tolerance_band_pair_matcher (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // shaft_size [17:0], hole_size [35:18], zero pad
   input  logic [tbpm_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // shaft_id, shaft_value, hole_id, hole_value, clearance, zero pad
   output logic [tbpm_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // status
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tbpm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tbpm_pkg::SIZE_W-1:0]         csr_data
);
   tbpm_pkg::cmd_type    cmd;
   tbpm_pkg::status_type status;
   logic                 csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // controller
   tbpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath
   tbpm_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // checks
   `TBPM_ASSERT_SAME(a_one_cmd, clock, reset, 1'b1, $onehot0(cmd))
   `TBPM_ASSERT_SAME(a_store_not_full, clock, reset, cmd.store, !status.full)
   `TBPM_ASSERT_NEXT(a_fail_result, clock, reset, cmd.fail, rsp_tvalid && rsp_tuser && rsp_tlast)
endmodule
